>>> rtl/slpt_pkg.sv
`default_nettype none

package slpt_pkg;

	// Field widths
	localparam int FUNC_W = 2;
	localparam int CALL_W = 8;
	localparam int DIST_W = 3;
	localparam int WORD_W = 8;

	// Schema layout: eight 3-bit window positions
	localparam int SLOTS  = 8;
	localparam int POS_W  = 3;

	// Configuration register widths
	localparam int WSIZE_W = 4;
	localparam int SCNT_W  = 4;
	localparam int SPOS_W  = SLOTS * POS_W;
	localparam int CIDX_W  = 2;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_WINDOW_SIZE      = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_SCHEMA_COUNT     = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_SCHEMA_POSITIONS = 2'd2;

	// Configuration reset values
	localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST      = 4'd8;
	localparam logic [SCNT_W-1:0]  SCHEMA_COUNT_RST     = 4'd8;
	localparam logic [SPOS_W-1:0]  SCHEMA_POSITIONS_RST = 24'd16434824;

	// Item kinds
	localparam logic [FUNC_W-1:0] FN_LEARN   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_PRELOAD = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY   = 2'd2;

	typedef struct packed {
		logic [WSIZE_W-1:0] win_len;
		logic [SCNT_W-1:0]  schema_count;
		logic [SPOS_W-1:0]  schema_positions;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_step;  // write one zero word of the clearing pass
		logic accept;    // take the input item, slide the window on learn
		logic setup;     // evaluate the item, reset the pair counter
		logic issue;     // start one memory operation
		logic out_load;  // move the result into the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;  // last word of the clearing pass is being written
		logic do_mem;      // item needs memory operations
		logic last_op;     // current operation is the last of the item
	} dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/slpt_ctrl.sv
`default_nettype none

module slpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  slpt_pkg::dp_sts_t sts,
	output slpt_pkg::dp_cmd_t cmd
);
	import slpt_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_SETUP  = 6'b000100,
		ST_PAIR   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   m_valid_q;
	logic   out_free;

	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.do_mem ? ST_PAIR : ST_FINISH;
			end
			ST_PAIR: begin
				cmd.issue = 1'b1;
				if (sts.last_op) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/slpt_dpath.sv
`default_nettype none

module slpt_dpath #(
	parameter int NUM_CALLS = 256,
	parameter int MAX_WIN   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slpt_pkg::cfg_t                cfg,
	input  logic [slpt_pkg::FUNC_W-1:0]   item_func,
	input  logic [slpt_pkg::CALL_W-1:0]   item_call,
	input  logic [slpt_pkg::CALL_W-1:0]   item_prior,
	input  logic [slpt_pkg::DIST_W-1:0]   item_dist,
	input  slpt_pkg::dp_cmd_t             cmd,
	output slpt_pkg::dp_sts_t             sts,
	output logic                          window_full,
	output logic [slpt_pkg::WORD_W-1:0]   stored_bits,
	output logic                          config_error
);
	import slpt_pkg::*;

	// Only codes below both NUM_CALLS and the call code range reach memory
	localparam int CODES = (NUM_CALLS < (1 << CALL_W)) ? NUM_CALLS : (1 << CALL_W);
	localparam int IW    = (CODES > 1) ? $clog2(CODES) : 1;
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int WW    = $clog2(MAX_WIN + 1);

	// Item registers
	logic [FUNC_W-1:0] func_q;
	logic [CALL_W-1:0] call_q;
	logic [CALL_W-1:0] prior_q;
	logic [DIST_W-1:0] dist_q;

	// Window state
	logic [CALL_W-1:0] win_q [MAX_WIN];
	logic [WW-1:0]     fill_q;

	logic [POS_W-1:0]  i_q;
	logic              full_q;
	logic [WORD_W-1:0] stored_q;

	logic              out_full_q;
	logic [WORD_W-1:0] out_bits_q;
	logic              out_err_q;

	// Memory operation stage
	logic              op_vld_s1;
	logic              op_wr_s1;
	logic              op_ok_s1;
	logic [AW-1:0]     addr_s1;
	logic [WORD_W-1:0] mask_s1;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic              lw_en_q;
	logic [AW-1:0]     lw_addr_q;
	logic [WORD_W-1:0] lw_data_q;
	logic [AW-1:0]     clr_q;

	// Configuration decode
	logic [WW-1:0]     w_eff;
	logic [SCNT_W-1:0] n_eff;
	logic [POS_W-1:0]  pos_a [SLOTS];
	logic              bad;
	logic              full_now;

	// Pair selection
	logic [POS_W-1:0]  lat_slot;
	logic [WW-1:0]     lat_idx;
	logic [WW-1:0]     ear_idx;
	logic [CALL_W-1:0] later;
	logic [CALL_W-1:0] earlier;
	logic [DIST_W-1:0] dist_l;

	// Operation source
	logic [CALL_W-1:0] a_later;
	logic [CALL_W-1:0] a_earlier;
	logic [WORD_W-1:0] a_mask;
	logic              a_wr;
	logic              a_ok;
	logic [AW-1:0]     a_addr;

	logic [WORD_W-1:0] old_word;
	logic              rmw_we;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	always_comb begin
		if (32'(cfg.win_len) < 2) begin
			w_eff = WW'(2);
		end else if (32'(cfg.win_len) > MAX_WIN) begin
			w_eff = WW'(MAX_WIN);
		end else begin
			w_eff = WW'(cfg.win_len);
		end
		n_eff = (32'(cfg.schema_count) > SLOTS) ? SCNT_W'(SLOTS) : cfg.schema_count;
	end

	always_comb begin
		bad = 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			pos_a[k] = cfg.schema_positions[k*POS_W +: POS_W];
			if (32'(k) < 32'(n_eff) && 32'(pos_a[k]) >= 32'(w_eff)) begin
				bad = 1'b1;
			end
		end
	end

	assign full_now = (fill_q >= w_eff) && !bad;

	// Window index of a schema entry: newest-first storage, oldest at w-1
	assign lat_slot = POS_W'(n_eff - SCNT_W'(1));
	assign lat_idx  = w_eff - WW'(1) - WW'(pos_a[lat_slot]);
	assign ear_idx  = w_eff - WW'(1) - WW'(pos_a[i_q]);
	assign dist_l   = DIST_W'(n_eff - SCNT_W'(1) - SCNT_W'(i_q));

	always_comb begin
		later   = '0;
		earlier = '0;
		for (int k = 0; k < MAX_WIN; k++) begin
			if (lat_idx == WW'(k)) begin
				later = win_q[k];
			end
			if (ear_idx == WW'(k)) begin
				earlier = win_q[k];
			end
		end
	end

	always_comb begin
		if (func_q == FN_LEARN) begin
			a_later   = later;
			a_earlier = earlier;
			a_mask    = WORD_W'(1) << dist_l;
			a_wr      = 1'b1;
		end else begin
			a_later   = call_q;
			a_earlier = prior_q;
			a_mask    = WORD_W'(1) << dist_q;
			a_wr      = (func_q == FN_PRELOAD);
		end
		a_ok   = (32'(a_later) < NUM_CALLS) && (32'(a_earlier) < NUM_CALLS);
		a_addr = {a_later[IW-1:0], a_earlier[IW-1:0]};
	end

	assign sts.do_mem = (func_q == FN_LEARN && full_now && n_eff >= SCNT_W'(2)) ||
	                    func_q == FN_PRELOAD || func_q == FN_QUERY;
	assign sts.last_op    = (func_q != FN_LEARN) ||
	                        (SCNT_W'(i_q) == n_eff - SCNT_W'(2));
	assign sts.clear_done = &clr_q;

	// A read issued in the same cycle as a write to its address returns stale data
	assign old_word  = (lw_en_q && lw_addr_q == addr_s1) ? lw_data_q : rdata_q;
	assign rmw_we    = op_vld_s1 && op_wr_s1 && op_ok_s1;
	assign mem_we    = cmd.clr_step || rmw_we;
	assign mem_waddr = cmd.clr_step ? clr_q : addr_s1;
	assign mem_wdata = cmd.clr_step ? '0 : (old_word | mask_s1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.issue) begin
			rdata_q <= mem[a_addr];
		end
	end

	always_ff @(posedge clk) begin
		lw_addr_q <= mem_waddr;
		lw_data_q <= mem_wdata;
		if (cmd.accept) begin
			func_q  <= item_func;
			call_q  <= item_call;
			prior_q <= item_prior;
			dist_q  <= item_dist;
		end
		if (cmd.issue) begin
			op_wr_s1 <= a_wr;
			op_ok_s1 <= a_ok;
			addr_s1  <= a_addr;
			mask_s1  <= a_mask;
		end
		if (cmd.setup) begin
			full_q   <= (func_q == FN_LEARN) && full_now;
			stored_q <= '0;
		end else if (op_vld_s1 && !op_wr_s1) begin
			stored_q <= op_ok_s1 ? old_word : '0;
		end
		if (cmd.out_load) begin
			out_full_q <= full_q;
			out_bits_q <= stored_q;
			out_err_q  <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_WIN; k++) begin
				win_q[k] <= '0;
			end
			fill_q    <= '0;
			i_q       <= '0;
			op_vld_s1 <= 1'b0;
			lw_en_q   <= 1'b0;
			clr_q     <= '0;
		end else begin
			op_vld_s1 <= cmd.issue;
			lw_en_q   <= mem_we;
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.accept && item_func == FN_LEARN) begin
				for (int k = MAX_WIN - 1; k > 0; k--) begin
					win_q[k] <= win_q[k-1];
				end
				win_q[0] <= item_call;
				if (32'(fill_q) < MAX_WIN) begin
					fill_q <= fill_q + WW'(1);
				end
			end
			if (cmd.setup) begin
				i_q <= '0;
			end else if (cmd.issue) begin
				i_q <= i_q + POS_W'(1);
			end
		end
	end

	assign window_full  = out_full_q;
	assign stored_bits  = out_bits_q;
	assign config_error = out_err_q;

endmodule

`default_nettype wire

>>> rtl/syscall_lookahead_pair_trainer.sv
// Lookahead-pair trainer for system call traces. Learn beats slide a call
// code into a window of the newest MAX_WIN calls; once the configured window
// length of calls is held and the schema is legal, the schema picks window
// entries and the block sets bit (distance) of the pair word addressed by
// (last picked call, earlier picked call) for every earlier schema entry.
// Preload beats set one pair bit, query beats return one pair word. Every
// input beat gives exactly one result beat. The pair memory has a single
// read-modify-write path, one pair operation per cycle with write-to-read
// forwarding. A new beat is taken while a result still waits in the output
// register; that beat then holds its result until the output register frees.
// After reset the pair memory is swept to zero, one word a cycle, over all
// P*P words where P is min(NUM_CALLS, 256) rounded up to a power of two;
// s_tready stays low during the sweep while configuration writes are taken
// as usual. Configuration is to be written by the user only while the block
// is idle; the block itself does not enforce this.
`default_nettype none

module syscall_lookahead_pair_trainer #(
	parameter int NUM_CALLS = 256,
	parameter int MAX_WIN   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,    // call_id[7:0], prior_call[15:8],
	                                                  // distance[18:16], zero[23:19]
	input  logic [slpt_pkg::FUNC_W-1:0]   s_tuser,    // func[1:0]
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,    // window_full[0], stored_bits[8:1],
	                                                  // config_error[9], zero[15:10]
	// Configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [slpt_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [slpt_pkg::SPOS_W-1:0]   cfg_data
);
	import slpt_pkg::*;

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	logic              window_full;
	logic [WORD_W-1:0] stored_bits;
	logic              config_error;

	// Registers take a write in any cycle; unknown indexes drop the beat
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_len          <= WINDOW_SIZE_RST;
			cfg_q.schema_count     <= SCHEMA_COUNT_RST;
			cfg_q.schema_positions <= SCHEMA_POSITIONS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WINDOW_SIZE:      cfg_q.win_len          <= cfg_data[WSIZE_W-1:0];
				CFG_SCHEMA_COUNT:     cfg_q.schema_count     <= cfg_data[SCNT_W-1:0];
				CFG_SCHEMA_POSITIONS: cfg_q.schema_positions <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequence the clearing sweep, item setup, pair operations and result hand-off
	slpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Window, schema selection, pair memory and output register
	slpt_dpath #(
		.NUM_CALLS (NUM_CALLS),
		.MAX_WIN   (MAX_WIN)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_func    (s_tuser),
		.item_call    (s_tdata[7:0]),
		.item_prior   (s_tdata[15:8]),
		.item_dist    (s_tdata[18:16]),
		.cmd          (cmd),
		.sts          (sts),
		.window_full  (window_full),
		.stored_bits  (stored_bits),
		.config_error (config_error)
	);

	// Pack the result beat
	assign m_tdata = {6'd0, config_error, stored_bits, window_full};

endmodule

`default_nettype wire

>>> rtl/slpt_checker.sv
`default_nettype none

module slpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// Items accepted whose result beat has not gone out yet
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result beat with no item behind it");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items held");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[8:1] == 8'd0 && !m_tdata[9])
		else $error("learn result carries pair bits or a schema error");

endmodule

bind syscall_lookahead_pair_trainer slpt_checker u_slpt_checker (.*);

`default_nettype wire

>>> tb/sv/tb_syscall_lookahead_pair_trainer.sv
`timescale 1ns / 100ps

module tb_syscall_lookahead_pair_trainer;
	import slpt_pkg::*;

	// Block sizes at the default parameters
	localparam int          NUM_CALLS = 256;
	localparam int unsigned WIN_DEPTH = 8;

	// The fourth item kind does nothing but report config_error
	localparam logic [FUNC_W-1:0] FN_IDLE = 2'd3;

	// Receiver hold-off long enough to back the block up into its input
	localparam int unsigned LONG_HOLD = 400;

	// Generous cycle budget: clearing sweep plus every item at its slowest
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CALL_W-1:0] call;
		logic [CALL_W-1:0] prior;
		logic [DIST_W-1:0] distance;
		logic              sync;      // wait for all results before offering
	} call_item_t;

	typedef struct packed {
		logic              full;
		logic [WORD_W-1:0] bits;
		logic              cfg_err;
	} pair_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [23:0]         s_tdata = '0;   // call_id[7:0], prior_call[15:8],
	                                     // distance[18:16], zero[23:19]
	logic [FUNC_W-1:0]   s_tuser = '0;   // func[1:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [15:0]         m_tdata;        // window_full[0], stored_bits[8:1],
	                                     // config_error[9], zero[15:10]
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [SPOS_W-1:0]   cfg_data = '0;

	// Shadow of the trainer: window, fill count, pair memory, registers
	bit   [CALL_W-1:0]   recent_calls [WIN_DEPTH];
	int unsigned         calls_held = 0;
	bit   [WORD_W-1:0]   pair_words [0:NUM_CALLS*NUM_CALLS-1];
	logic [WSIZE_W-1:0]  win_size_reg = WINDOW_SIZE_RST;
	logic [SCNT_W-1:0]   schema_cnt_reg = SCHEMA_COUNT_RST;
	logic [SPOS_W-1:0]   schema_pos_reg = SCHEMA_POSITIONS_RST;

	call_item_t          trace_items [$];
	pair_result_t        pair_outcomes [$];

	int unsigned         fail_count = 0;
	int unsigned         beats_seen = 0;
	int unsigned         items_made = 0;
	int unsigned         cycle_count = 0;

	// Sender and receiver pacing
	int unsigned         tx_gap = 0;
	int unsigned         tx_calm = 0;
	int unsigned         rx_stall = 0;
	int unsigned         rx_calm = 0;
	bit                  long_hold_done = 1'b0;

	// Per-phase alphabet of call codes, so that pairs recur and queries hit
	logic [CALL_W-1:0]   alpha [8];
	int unsigned         alpha_n = 1;

	syscall_lookahead_pair_trainer #(
		.NUM_CALLS(NUM_CALLS),
		.MAX_WIN  (WIN_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Advance the shadow trainer by one accepted beat and return its result
	function automatic pair_result_t train_step(input call_item_t it);
		pair_result_t      r;
		int unsigned       w;
		int unsigned       n;
		int unsigned       i;
		logic              bad;
		logic [CALL_W-1:0] sel [SLOTS];
		r = '0;
		// Clamp the window to 2..MAX_WIN and the schema count to the slot count
		w = 32'(win_size_reg);
		if (w < 2) w = 2;
		if (w > WIN_DEPTH) w = WIN_DEPTH;
		n = (32'(schema_cnt_reg) > SLOTS) ? SLOTS : 32'(schema_cnt_reg);
		bad = 1'b0;
		for (i = 0; i < n; i++)
			if (32'(schema_pos_reg[POS_W*i +: POS_W]) >= w) bad = 1'b1;
		r.cfg_err = bad;
		case (it.func)
			FN_LEARN: begin
				// Slide the window even when the schema is illegal
				for (i = WIN_DEPTH - 1; i > 0; i--) recent_calls[i] = recent_calls[i-1];
				recent_calls[0] = it.call;
				if (calls_held < WIN_DEPTH) calls_held++;
				if (calls_held >= w && !bad) begin
					r.full = 1'b1;
					// Position zero is the oldest call of the effective window
					for (i = 0; i < n; i++)
						sel[i] = recent_calls[w - 1 - 32'(schema_pos_reg[POS_W*i +: POS_W])];
					for (i = 0; i + 1 < n; i++)
						pair_words[{sel[n-1], sel[i]}][n - 1 - i] = 1'b1;
				end
			end
			FN_PRELOAD: begin
				pair_words[{it.call, it.prior}][it.distance] = 1'b1;
			end
			FN_QUERY: begin
				r.bits = pair_words[{it.call, it.prior}];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Sender: offer the head of the trace queue, hold it until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pair_outcomes.insert(pair_outcomes.size(),
				                     train_step(trace_items.pop_front()));
				if (tx_calm > 0) begin
					tx_calm--;
					tx_gap = 0;
				end else begin
					tx_gap = idle_len();
					if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(20, 60);
				end
			end
			if (s_tvalid && !s_tready) begin
				// hold the beat until the block takes it
			end else if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (trace_items.size() > 0 &&
			             !(trace_items[0].sync && pair_outcomes.size() > 0)) begin
				s_tvalid <= 1'b1;
				s_tuser  <= trace_items[0].func;
				s_tdata  <= {5'b0, trace_items[0].distance, trace_items[0].prior,
				             trace_items[0].call};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: check every result beat against the oldest prediction
	always @(posedge clk) begin
		pair_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (pair_outcomes.size() == 0) begin
					$error("result beat with nothing predicted: %h", m_tdata);
					fail_count++;
				end else begin
					want = pair_outcomes.pop_front();
					if (m_tdata[0] !== want.full) begin
						$error("window_full expected %0d actual %0d", want.full, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[8:1] !== want.bits) begin
						$error("stored_bits expected %h actual %h", want.bits, m_tdata[8:1]);
						fail_count++;
					end
					if (m_tdata[9] !== want.cfg_err) begin
						$error("config_error expected %0d actual %0d", want.cfg_err,
						       m_tdata[9]);
						fail_count++;
					end
					if (m_tdata[15:10] !== 6'd0) begin
						$error("pad expected 0 actual %h", m_tdata[15:10]);
						fail_count++;
					end
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && beats_seen >= 200 && trace_items.size() >= 8) begin
				// Hold off long enough for the block to stall its input
				long_hold_done = 1'b1;
				rx_stall = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (rx_calm > 0) begin
				rx_calm--;
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 1) == 0) begin
				rx_stall = idle_len();
				m_tready <= (rx_stall == 0);
				if (rx_stall > 0) rx_stall--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 60);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_item(input logic [FUNC_W-1:0] func, input logic [CALL_W-1:0] call,
	                         input logic [CALL_W-1:0] prior, input logic [DIST_W-1:0] d,
	                         input logic sync);
		call_item_t it;
		it.func     = func;
		it.call     = call;
		it.prior    = prior;
		it.distance = d;
		it.sync     = sync;
		trace_items.insert(trace_items.size(), it);
		items_made++;
	endtask

	// Write one register and mirror it once the beat is taken
	task automatic write_cfg(input logic [CIDX_W-1:0] idx, input logic [SPOS_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WINDOW_SIZE:      win_size_reg   = val[WSIZE_W-1:0];
			CFG_SCHEMA_COUNT:     schema_cnt_reg = val[SCNT_W-1:0];
			CFG_SCHEMA_POSITIONS: schema_pos_reg = val;
			default: begin
			end
		endcase
	endtask

	// Wait until every item is taken and every result has come back
	task automatic drain();
		while (trace_items.size() != 0 || pair_outcomes.size() != 0) @(posedge clk);
	endtask

	// Schema whose eight positions all fall inside a window of w calls
	function automatic logic [SPOS_W-1:0] legal_schema(input int unsigned w);
		logic [SPOS_W-1:0] s;
		int unsigned       i;
		for (i = 0; i < SLOTS; i++) s[POS_W*i +: POS_W] = POS_W'($urandom_range(0, w - 1));
		return s;
	endfunction

	// Mostly learn runs over a small alphabet, with preloads, queries of pairs
	// that learning likely set, and some noise of every kind
	task automatic gen_trace_item();
		int unsigned       r;
		logic [CALL_W-1:0] c;
		logic [CALL_W-1:0] p;
		logic              sync;
		r = $urandom_range(0, 99);
		sync = ($urandom_range(0, 49) == 0);
		if (r < 55) begin
			c = ($urandom_range(0, 99) < 85) ? alpha[$urandom_range(0, alpha_n - 1)]
			                                 : CALL_W'($urandom_range(0, 255));
			push_item(FN_LEARN, c, CALL_W'($urandom_range(0, 255)),
			          DIST_W'($urandom_range(0, 7)), sync);
		end else if (r < 70) begin
			c = ($urandom_range(0, 1) == 0) ? alpha[$urandom_range(0, alpha_n - 1)]
			                                : CALL_W'($urandom_range(0, 255));
			p = ($urandom_range(0, 1) == 0) ? alpha[$urandom_range(0, alpha_n - 1)]
			                                : CALL_W'($urandom_range(0, 255));
			push_item(FN_PRELOAD, c, p, DIST_W'($urandom_range(0, 7)), sync);
		end else if (r < 94) begin
			if ($urandom_range(0, 99) < 75) begin
				c = alpha[$urandom_range(0, alpha_n - 1)];
				p = alpha[$urandom_range(0, alpha_n - 1)];
			end else begin
				c = CALL_W'($urandom_range(0, 255));
				p = CALL_W'($urandom_range(0, 255));
			end
			push_item(FN_QUERY, c, p, DIST_W'($urandom_range(0, 7)), sync);
		end else begin
			push_item(FUNC_W'($urandom_range(0, 3)), CALL_W'($urandom_range(0, 255)),
			          CALL_W'($urandom_range(0, 255)), DIST_W'($urandom_range(0, 7)), sync);
		end
	endtask

	// Set up the registers while idle, then run one batch of random items
	task automatic run_phase(input logic [WSIZE_W-1:0] ws, input logic [SCNT_W-1:0] sc,
	                         input logic [SPOS_W-1:0] pos, input int unsigned count);
		logic [31:0] junk;
		int unsigned i;
		junk = $urandom;
		// Upper data bits of the narrow registers carry junk, which must drop
		write_cfg(CFG_WINDOW_SIZE, {junk[19:0], ws});
		write_cfg(CFG_SCHEMA_COUNT, {junk[31:12], sc});
		write_cfg(CFG_SCHEMA_POSITIONS, pos);
		alpha_n = $urandom_range(3, 8);
		for (i = 0; i < 8; i++) alpha[i] = CALL_W'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0) alpha[0] = 8'h00;
		if ($urandom_range(0, 3) == 0) alpha[1] = 8'hFF;
		for (i = 0; i < count; i++) gen_trace_item();
		drain();
	endtask

	initial begin
		logic [WSIZE_W-1:0] ws;
		logic [SCNT_W-1:0]  sc;
		logic [SPOS_W-1:0]  pos;
		int unsigned        w;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings: identity schema over eight calls
		push_item(FN_QUERY, 8'h00, 8'h00, 3'd0, 1'b0);     // cleared memory
		push_item(FN_QUERY, 8'hFF, 8'hFF, 3'd7, 1'b0);
		push_item(FN_LEARN, 8'h00, 8'hFF, 3'd7, 1'b0);     // window still filling
		push_item(FN_LEARN, 8'hFF, 8'h00, 3'd0, 1'b0);
		push_item(FN_LEARN, 8'h12, 8'h00, 3'd0, 1'b0);
		push_item(FN_LEARN, 8'h34, 8'h00, 3'd0, 1'b0);
		push_item(FN_LEARN, 8'h56, 8'h00, 3'd0, 1'b0);
		push_item(FN_LEARN, 8'h78, 8'h00, 3'd0, 1'b0);
		push_item(FN_LEARN, 8'h9A, 8'h00, 3'd0, 1'b0);
		push_item(FN_LEARN, 8'hFF, 8'h00, 3'd0, 1'b0);     // first full window
		push_item(FN_QUERY, 8'hFF, 8'h00, 3'd0, 1'b0);     // farthest distance
		push_item(FN_QUERY, 8'hFF, 8'hFF, 3'd0, 1'b0);
		push_item(FN_QUERY, 8'hFF, 8'h9A, 3'd0, 1'b0);     // nearest distance
		push_item(FN_PRELOAD, 8'h00, 8'hFF, 3'd0, 1'b0);
		push_item(FN_PRELOAD, 8'h00, 8'h00, 3'd7, 1'b0);
		push_item(FN_PRELOAD, 8'hA5, 8'h5A, 3'd3, 1'b0);
		push_item(FN_QUERY, 8'h00, 8'hFF, 3'd0, 1'b0);
		push_item(FN_QUERY, 8'h00, 8'h00, 3'd0, 1'b0);
		push_item(FN_QUERY, 8'hA5, 8'h5A, 3'd0, 1'b0);
		push_item(FN_IDLE, 8'hFF, 8'hFF, 3'd7, 1'b0);      // no operation
		push_item(FN_IDLE, 8'h00, 8'h00, 3'd0, 1'b0);
		push_item(FN_LEARN, 8'h00, 8'h00, 3'd0, 1'b1);     // after a full pause
		push_item(FN_QUERY, 8'h00, 8'h12, 3'd0, 1'b0);
		drain();

		// Extreme settings, the window state carrying over between them
		run_phase(4'd2, 4'd2, legal_schema(2), 70);            // smallest window
		run_phase(4'd8, 4'd8, legal_schema(8), 90);            // largest window
		run_phase(4'd0, 4'd8, legal_schema(2), 60);            // size clamped up
		run_phase(4'd15, 4'd15, legal_schema(8), 80);          // size and count clamped
		run_phase(4'd5, 4'd1, SPOS_W'($urandom_range(0, 24'hFFFFFF)), 50);  // count below two
		run_phase(4'd3, 4'd0, SPOS_W'($urandom_range(0, 24'hFFFFFF)), 50);
		run_phase(4'd8, 4'd8, 24'hFFFFFF, 70);                 // all newest
		run_phase(4'd4, 4'd8, 24'hFFFFFF, 50);                 // illegal schema
		run_phase(4'd6, 4'd3, 24'h000000, 60);                 // all oldest
		run_phase(4'd1, 4'd2, legal_schema(2), 50);

		// Random settings, mostly legal schemas so that pairs get recorded
		while (items_made < 1400) begin
			ws = WSIZE_W'($urandom_range(0, 15));
			sc = ($urandom_range(0, 99) < 80) ? SCNT_W'($urandom_range(2, 8))
			                                  : SCNT_W'($urandom_range(0, 15));
			w = 32'(ws);
			if (w < 2) w = 2;
			if (w > WIN_DEPTH) w = WIN_DEPTH;
			pos = ($urandom_range(0, 99) < 80) ? legal_schema(w)
			                                   : SPOS_W'($urandom_range(0, 24'hFFFFFF));
			run_phase(ws, sc, pos, $urandom_range(50, 110));
		end

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
